@@ hw/rtl/axis_angle_rotation_matrix_assert.svh @@
// Assertion macros for the axis-angle rotation matrix block
`ifndef AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define AAR_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("aar check failed");

// Check that a condition implies another a fixed number of cycles later
`define AAR_ASSERT_DELAY(lbl, pre, dly, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##(dly) (post)) \
    else $error("aar latency check failed");

`endif

@@ hw/rtl/aar_pkg.sv @@
// Shared types, constants and functions of the axis-angle rotation matrix block
`timescale 1ns / 1ps
package aar_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int ENTRY_WIDTH  = 16;
  localparam int ONE_Q14      = 16384;

  // Normalisation datapath widths
  localparam int MAG_WIDTH    = COORD_WIDTH;
  localparam int N2_WIDTH     = 2 * COORD_WIDTH;
  localparam int RAD_WIDTH    = N2_WIDTH + 28;
  localparam int SQRT_STAGES  = RAD_WIDTH / 2;
  localparam int ROOT_WIDTH   = SQRT_STAGES;
  localparam int REM_WIDTH    = ROOT_WIDTH + 4;
  localparam int DIV_STAGES   = ENTRY_WIDTH - 1;
  localparam int DVD_WIDTH    = MAG_WIDTH + 28;

  // Sine and cosine datapath widths
  localparam int CORDIC_STEPS = 16;
  localparam int XY_WIDTH     = 34;
  localparam int Z_WIDTH      = 32;
  localparam logic signed [XY_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;

  // Products and result
  localparam int UU_WIDTH     = 2 * ENTRY_WIDTH;
  localparam int OMC_WIDTH    = XY_WIDTH + 1;
  localparam int US_WIDTH     = ENTRY_WIDTH + XY_WIDTH;
  localparam int SUM_WIDTH    = 64;

  // Accept edge to the edge that samples out_valid high
  localparam int LATENCY      = 2 + SQRT_STAGES + DIV_STAGES + CORDIC_STEPS + 3;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] axis_x;
    logic signed [COORD_WIDTH-1:0] axis_y;
    logic signed [COORD_WIDTH-1:0] axis_z;
    logic [ANGLE_WIDTH-1:0]        angle_turns;
  } in_t;

  typedef struct packed {
    logic signed [ENTRY_WIDTH-1:0] r00;
    logic signed [ENTRY_WIDTH-1:0] r01;
    logic signed [ENTRY_WIDTH-1:0] r02;
    logic signed [ENTRY_WIDTH-1:0] r10;
    logic signed [ENTRY_WIDTH-1:0] r11;
    logic signed [ENTRY_WIDTH-1:0] r12;
    logic signed [ENTRY_WIDTH-1:0] r20;
    logic signed [ENTRY_WIDTH-1:0] r21;
    logic signed [ENTRY_WIDTH-1:0] r22;
    logic                          zero_axis;
  } out_t;

  // Unit axis leaving the normaliser
  typedef struct packed {
    logic signed [ENTRY_WIDTH-1:0] ux;
    logic signed [ENTRY_WIDTH-1:0] uy;
    logic signed [ENTRY_WIDTH-1:0] uz;
    logic [ANGLE_WIDTH-1:0]        angle;
    logic                          zero;
  } unit_t;

  // Unit axis with cosine and sine in Q30
  typedef struct packed {
    unit_t                      u;
    logic signed [XY_WIDTH-1:0] cs;
    logic signed [XY_WIDTH-1:0] sn;
  } trig_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [Z_WIDTH-1:0] atan_turns(input logic [3:0] idx);
    logic [Z_WIDTH-1:0] r;
    case (idx)
      4'd0:    r = 32'h20000000;
      4'd1:    r = 32'h12E4051E;
      4'd2:    r = 32'h09FB385B;
      4'd3:    r = 32'h051111D4;
      4'd4:    r = 32'h028B0D43;
      4'd5:    r = 32'h0145D7E1;
      4'd6:    r = 32'h00A2F61E;
      4'd7:    r = 32'h00517C55;
      4'd8:    r = 32'h0028BE53;
      4'd9:    r = 32'h00145F2F;
      4'd10:   r = 32'h000A2F98;
      4'd11:   r = 32'h000517CC;
      4'd12:   r = 32'h00028BE6;
      4'd13:   r = 32'h000145F3;
      4'd14:   r = 32'h0000A2FA;
      4'd15:   r = 32'h0000517D;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round a Q58 sum to Q1.14, halves upward, and saturate
  function automatic logic signed [ENTRY_WIDTH-1:0] to_q14(
      input logic signed [SUM_WIDTH-1:0] sum);
    logic signed [SUM_WIDTH-1:0] r;
    logic signed [ENTRY_WIDTH-1:0] o;
    r = (sum + (64'sd1 <<< 43)) >>> 44;
    if (r > 64'sd16384) begin
      o = 16'sd16384;
    end else if (r < -64'sd16384) begin
      o = -16'sd16384;
    end else begin
      o = r[ENTRY_WIDTH-1:0];
    end
    return o;
  endfunction

endpackage

@@ hw/rtl/aar_norm.sv @@
// Axis normaliser: squared norm, pipelined square root and pipelined division
`timescale 1ns / 1ps
module aar_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  aar_pkg::in_t   in_data,
  output logic           out_valid,
  output aar_pkg::unit_t out_unit
);

  typedef struct packed {
    logic [2:0][aar_pkg::MAG_WIDTH-1:0] mag;
    logic [2:0]                         neg;
    logic [aar_pkg::N2_WIDTH-1:0]       n2;
    logic [aar_pkg::ROOT_WIDTH-1:0]     root;
    logic [aar_pkg::REM_WIDTH-1:0]      rem;
    logic [aar_pkg::ANGLE_WIDTH-1:0]    angle;
    logic                               zero;
  } sq_t;

  typedef struct packed {
    logic [2:0][aar_pkg::DVD_WIDTH-1:0]    rem;
    logic [2:0][aar_pkg::DIV_STAGES-1:0]   quo;
    logic [2:0]                            neg;
    logic [aar_pkg::ROOT_WIDTH-1:0]        q;
    logic [aar_pkg::ANGLE_WIDTH-1:0]       angle;
    logic                                  zero;
  } dv_t;

  sq_t  sq_r   [0:aar_pkg::SQRT_STAGES];
  logic sq_v_r [0:aar_pkg::SQRT_STAGES];
  sq_t  sq_nxt;
  dv_t  dv_r   [0:aar_pkg::DIV_STAGES-1];
  logic dv_v_r [0:aar_pkg::DIV_STAGES-1];
  dv_t  dv_init;

  // Take magnitudes and the squared norm
  always_comb begin
    logic signed [aar_pkg::COORD_WIDTH-1:0] v [0:2];
    v[0] = in_data.axis_x;
    v[1] = in_data.axis_y;
    v[2] = in_data.axis_z;
    sq_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      sq_nxt.neg[i] = v[i][aar_pkg::COORD_WIDTH-1];
      sq_nxt.mag[i] = v[i][aar_pkg::COORD_WIDTH-1] ? (~v[i] + 1'b1) : v[i];
    end
    sq_nxt.n2 = aar_pkg::N2_WIDTH'(sq_nxt.mag[0]) * aar_pkg::N2_WIDTH'(sq_nxt.mag[0])
              + aar_pkg::N2_WIDTH'(sq_nxt.mag[1]) * aar_pkg::N2_WIDTH'(sq_nxt.mag[1])
              + aar_pkg::N2_WIDTH'(sq_nxt.mag[2]) * aar_pkg::N2_WIDTH'(sq_nxt.mag[2]);
    sq_nxt.angle = in_data.angle_turns;
    sq_nxt.zero  = (sq_nxt.mag == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= in_valid;
    end
    sq_r[0] <= sq_nxt;
  end

  // Square root of n2 * 2^28, one root bit per stage
  for (genvar k = 0; k < aar_pkg::SQRT_STAGES; k++) begin : g_sqrt
    localparam int HI = aar_pkg::RAD_WIDTH - 1 - 2 * k;
    sq_t step_nxt;

    always_comb begin
      logic [aar_pkg::RAD_WIDTH-1:0] rad;
      logic [aar_pkg::REM_WIDTH-1:0] acc;
      logic [aar_pkg::REM_WIDTH-1:0] trial;
      rad   = {sq_r[k].n2, 28'b0};
      acc   = {sq_r[k].rem[aar_pkg::REM_WIDTH-3:0], rad[HI -: 2]};
      trial = aar_pkg::REM_WIDTH'({sq_r[k].root, 2'b01});
      step_nxt = sq_r[k];
      if (acc >= trial) begin
        step_nxt.rem  = acc - trial;
        step_nxt.root = {sq_r[k].root[aar_pkg::ROOT_WIDTH-2:0], 1'b1};
      end else begin
        step_nxt.rem  = acc;
        step_nxt.root = {sq_r[k].root[aar_pkg::ROOT_WIDTH-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
      sq_r[k+1] <= step_nxt;
    end
  end

  // Form rounded dividends |v| * 2^28 + q / 2
  always_comb begin
    logic [aar_pkg::ROOT_WIDTH-1:0] q;
    q = sq_r[aar_pkg::SQRT_STAGES].root;
    dv_init = '0;
    for (int i = 0; i < 3; i++) begin
      dv_init.rem[i] = {sq_r[aar_pkg::SQRT_STAGES].mag[i], 28'b0}
                     + aar_pkg::DVD_WIDTH'(q >> 1);
    end
    dv_init.neg   = sq_r[aar_pkg::SQRT_STAGES].neg;
    dv_init.q     = q;
    dv_init.angle = sq_r[aar_pkg::SQRT_STAGES].angle;
    dv_init.zero  = sq_r[aar_pkg::SQRT_STAGES].zero;
  end

  // Divide by the root, one quotient bit per stage on all three lanes
  for (genvar j = 0; j < aar_pkg::DIV_STAGES; j++) begin : g_div
    localparam int K = aar_pkg::DIV_STAGES - 1 - j;
    dv_t  src;
    logic src_v;
    dv_t  step_nxt;

    if (j == 0) begin : g_first
      assign src   = dv_init;
      assign src_v = sq_v_r[aar_pkg::SQRT_STAGES];
    end else begin : g_next
      assign src   = dv_r[j-1];
      assign src_v = dv_v_r[j-1];
    end

    always_comb begin
      logic [aar_pkg::DVD_WIDTH:0] dsh;
      dsh = (aar_pkg::DVD_WIDTH+1)'(src.q) << K;
      step_nxt = src;
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, src.rem[i]} >= dsh) begin
          step_nxt.rem[i]    = src.rem[i] - dsh[aar_pkg::DVD_WIDTH-1:0];
          step_nxt.quo[i][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else begin
        dv_v_r[j] <= src_v;
      end
      dv_r[j] <= step_nxt;
    end
  end

  // Saturate and apply signs
  always_comb begin
    logic [aar_pkg::ENTRY_WIDTH-1:0] mg [0:2];
    for (int i = 0; i < 3; i++) begin
      mg[i] = {1'b0, dv_r[aar_pkg::DIV_STAGES-1].quo[i]};
      if (mg[i] > aar_pkg::ENTRY_WIDTH'(aar_pkg::ONE_Q14)) begin
        mg[i] = aar_pkg::ENTRY_WIDTH'(aar_pkg::ONE_Q14);
      end
      if (dv_r[aar_pkg::DIV_STAGES-1].neg[i]) begin
        mg[i] = ~mg[i] + 1'b1;
      end
    end
    out_unit.ux    = mg[0];
    out_unit.uy    = mg[1];
    out_unit.uz    = mg[2];
    out_unit.angle = dv_r[aar_pkg::DIV_STAGES-1].angle;
    out_unit.zero  = dv_r[aar_pkg::DIV_STAGES-1].zero;
  end

  assign out_valid = dv_v_r[aar_pkg::DIV_STAGES-1];

endmodule

@@ hw/rtl/aar_cordic.sv @@
// Pipelined rotation-mode CORDIC giving cosine and sine of the angle
`timescale 1ns / 1ps
module aar_cordic (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  aar_pkg::unit_t in_unit,
  output logic           out_valid,
  output aar_pkg::trig_t out_trig
);

  typedef struct packed {
    aar_pkg::unit_t                      u;
    logic [1:0]                          quad;
    logic signed [aar_pkg::XY_WIDTH-1:0] x;
    logic signed [aar_pkg::XY_WIDTH-1:0] y;
    logic signed [aar_pkg::Z_WIDTH-1:0]  z;
  } cr_t;

  cr_t  cr_r   [0:aar_pkg::CORDIC_STEPS-1];
  logic cr_v_r [0:aar_pkg::CORDIC_STEPS-1];
  cr_t  cr_init;

  // Split the turn count into quadrant and residual
  always_comb begin
    logic [31:0] a32;
    a32 = {in_unit.angle, (32 - aar_pkg::ANGLE_WIDTH)'(0)};
    cr_init.u    = in_unit;
    cr_init.quad = a32[31:30];
    cr_init.x    = aar_pkg::CORDIC_GAIN;
    cr_init.y    = '0;
    cr_init.z    = {2'b00, a32[29:0]};
  end

  for (genvar i = 0; i < aar_pkg::CORDIC_STEPS; i++) begin : g_step
    cr_t  src;
    logic src_v;
    cr_t  step_nxt;

    if (i == 0) begin : g_first
      assign src   = cr_init;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = cr_r[i-1];
      assign src_v = cr_v_r[i-1];
    end

    // Rotate towards zero residual angle
    always_comb begin
      logic signed [aar_pkg::XY_WIDTH-1:0] dx;
      logic signed [aar_pkg::XY_WIDTH-1:0] dy;
      logic signed [aar_pkg::Z_WIDTH-1:0]  at;
      dx = src.y >>> i;
      dy = src.x >>> i;
      at = aar_pkg::atan_turns(4'(i));
      step_nxt = src;
      if (!src.z[aar_pkg::Z_WIDTH-1]) begin
        step_nxt.x = src.x - dx;
        step_nxt.y = src.y + dy;
        step_nxt.z = src.z - at;
      end else begin
        step_nxt.x = src.x + dx;
        step_nxt.y = src.y - dy;
        step_nxt.z = src.z + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cr_v_r[i] <= 1'b0;
      end else begin
        cr_v_r[i] <= src_v;
      end
      cr_r[i] <= step_nxt;
    end
  end

  // Map the residual result back by quarter turns
  always_comb begin
    cr_t last;
    last = cr_r[aar_pkg::CORDIC_STEPS-1];
    out_trig.u = last.u;
    case (last.quad)
      2'd0: begin
        out_trig.cs = last.x;
        out_trig.sn = last.y;
      end
      2'd1: begin
        out_trig.cs = -last.y;
        out_trig.sn = last.x;
      end
      2'd2: begin
        out_trig.cs = -last.x;
        out_trig.sn = -last.y;
      end
      default: begin
        out_trig.cs = last.y;
        out_trig.sn = -last.x;
      end
    endcase
  end

  assign out_valid = cr_v_r[aar_pkg::CORDIC_STEPS-1];

endmodule

@@ hw/rtl/axis_angle_rotation_matrix.sv @@
// Top level: axis-angle to 3x3 rotation matrix, fully pipelined
//
//  channel  ports                     handshake
//  input    start, busy, in_data      taken when start is high and busy low
//  result   out_valid, out_data       one-cycle strobe, no back-pressure
//
// One transaction is taken every cycle; busy is held low.
// The pipeline is the 30-stage square root, the 15-stage divider and the 16-stage
// CORDIC in series, plus input, squared-norm, product and output registers.
// Synchronous active-low reset clears every valid bit; data registers are not reset.
// Results leave on a strobe and are never held back.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  aar_pkg::in_t  in_data,
  output logic          out_valid,
  output aar_pkg::out_t out_data
);

  logic           in_v_r;
  aar_pkg::in_t   in_r;
  logic           nrm_valid;
  aar_pkg::unit_t nrm_unit;
  logic           trg_valid;
  aar_pkg::trig_t trg;

  logic                                 p1_v_r;
  logic signed [aar_pkg::UU_WIDTH-1:0]  uu_r  [0:2][0:2];
  logic signed [aar_pkg::US_WIDTH-1:0]  us1_r [0:2];
  logic signed [aar_pkg::XY_WIDTH-1:0]  c1_r;
  logic signed [aar_pkg::OMC_WIDTH-1:0] omc_r;
  logic                                 z1_r;

  logic                                 p2_v_r;
  logic signed [aar_pkg::SUM_WIDTH-1:0] mm_r  [0:2][0:2];
  logic signed [aar_pkg::US_WIDTH-1:0]  us2_r [0:2];
  logic signed [aar_pkg::XY_WIDTH-1:0]  c2_r;
  logic                                 z2_r;

  logic          out_v_r;
  aar_pkg::out_t out_r;
  aar_pkg::out_t out_nxt;

  assign busy = 1'b0;

  // Register the accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
    in_r <= in_data;
  end

  aar_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_v_r),
    .in_data   (in_r),
    .out_valid (nrm_valid),
    .out_unit  (nrm_unit)
  );

  aar_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nrm_valid),
    .in_unit   (nrm_unit),
    .out_valid (trg_valid),
    .out_trig  (trg)
  );

  // Axis outer products, sine terms and one minus cosine
  always_ff @(posedge clk) begin
    logic signed [aar_pkg::ENTRY_WIDTH-1:0] u [0:2];
    u[0] = trg.u.ux;
    u[1] = trg.u.uy;
    u[2] = trg.u.uz;
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= trg_valid;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        uu_r[i][j] <= u[i] * u[j];
      end
      us1_r[i] <= aar_pkg::US_WIDTH'(u[i]) * aar_pkg::US_WIDTH'(trg.sn);
    end
    c1_r  <= trg.cs;
    omc_r <= (aar_pkg::OMC_WIDTH'(1) <<< 30) - aar_pkg::OMC_WIDTH'(trg.cs);
    z1_r  <= trg.u.zero;
  end

  // Scale outer products by one minus cosine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else begin
      p2_v_r <= p1_v_r;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mm_r[i][j] <= aar_pkg::SUM_WIDTH'(uu_r[i][j]) * aar_pkg::SUM_WIDTH'(omc_r);
      end
    end
    us2_r <= us1_r;
    c2_r  <= c1_r;
    z2_r  <= z1_r;
  end

  // Add cosine and cross terms, round and saturate
  always_comb begin
    logic signed [aar_pkg::SUM_WIDTH-1:0] cq;
    logic signed [aar_pkg::SUM_WIDTH-1:0] sq [0:2];
    cq = aar_pkg::SUM_WIDTH'(c2_r) <<< 28;
    for (int i = 0; i < 3; i++) begin
      sq[i] = aar_pkg::SUM_WIDTH'(us2_r[i]) <<< 14;
    end
    out_nxt.r00 = aar_pkg::to_q14(mm_r[0][0] + cq);
    out_nxt.r01 = aar_pkg::to_q14(mm_r[0][1] - sq[2]);
    out_nxt.r02 = aar_pkg::to_q14(mm_r[0][2] + sq[1]);
    out_nxt.r10 = aar_pkg::to_q14(mm_r[1][0] + sq[2]);
    out_nxt.r11 = aar_pkg::to_q14(mm_r[1][1] + cq);
    out_nxt.r12 = aar_pkg::to_q14(mm_r[1][2] - sq[0]);
    out_nxt.r20 = aar_pkg::to_q14(mm_r[2][0] - sq[1]);
    out_nxt.r21 = aar_pkg::to_q14(mm_r[2][1] + sq[0]);
    out_nxt.r22 = aar_pkg::to_q14(mm_r[2][2] + cq);
    out_nxt.zero_axis = 1'b0;
    // Zero axis: return the identity
    if (z2_r) begin
      out_nxt     = '0;
      out_nxt.r00 = aar_pkg::ENTRY_WIDTH'(aar_pkg::ONE_Q14);
      out_nxt.r11 = aar_pkg::ENTRY_WIDTH'(aar_pkg::ONE_Q14);
      out_nxt.r22 = aar_pkg::ENTRY_WIDTH'(aar_pkg::ONE_Q14);
      out_nxt.zero_axis = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= p2_v_r;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/aar_checker.sv @@
// Port-level checker for the axis-angle rotation matrix block, with its bind
`timescale 1ns / 1ps
`include "axis_angle_rotation_matrix_assert.svh"
module aar_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input aar_pkg::out_t out_data
);

  // Every accepted transaction gives a result after the fixed latency
  `AAR_ASSERT_DELAY(a_latency, start && !busy, aar_pkg::LATENCY, out_valid)

  // No result without a transaction accepted that many cycles before
  `AAR_ASSERT_IMPL(a_no_spurious, out_valid, $past(start && !busy, aar_pkg::LATENCY))

  // Zero axis gives ones on the diagonal and zero in r01, r12 and r20
  `AAR_ASSERT_IMPL(a_identity, out_valid && out_data.zero_axis, (out_data.r00 == 16'sd16384) && (out_data.r11 == 16'sd16384) && (out_data.r22 == 16'sd16384) && (out_data.r01 == 16'sd0) && (out_data.r12 == 16'sd0) && (out_data.r20 == 16'sd0))

  // Entries r00, r12 and r21 stay within the saturation bounds
  `AAR_ASSERT_IMPL(a_range, out_valid, (out_data.r00 <= 16'sd16384) && (out_data.r00 >= -16'sd16384) && (out_data.r12 <= 16'sd16384) && (out_data.r12 >= -16'sd16384) && (out_data.r21 <= 16'sd16384) && (out_data.r21 >= -16'sd16384))

endmodule

bind axis_angle_rotation_matrix aar_checker u_aar_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the axis-angle rotation matrix block
`timescale 1ns / 1ps
module testbench;
  import aar_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 700;
  localparam int CALM_ITEMS     = 150;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  axis_angle_rotation_matrix u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  in_t    pending_axes[$];
  out_t   matrix_queue[$];
  int     calm_from;
  int     n_sent;
  int     n_checked;
  int     n_zero;
  int     n_errors = 0;
  int     gap_left;
  int     idle_cycles;
  bit     stim_done;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic longint arc_step(int i);
    case (i)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2F;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2FA;
      default: return 64'h0000517D;
    endcase
  endfunction

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint scale_unit(longint v, longint unsigned q);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? -v : v;
    r = ((mag << 28) + (q >> 1)) / q;
    if (r > ONE_Q14) r = ONE_Q14;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [15:0] round_entry(longint s);
    longint r;
    r = (s + (64'sd1 <<< 43)) >>> 44;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  // Expected rotation matrix for one axis and angle
  function automatic out_t rotation_of(in_t it);
    out_t   o;
    longint v[3];
    longint u[3];
    longint m[3][3];
    longint unsigned n2;
    longint unsigned q;
    longint x, y, z, dx, dy, cs, sn, omc;
    logic [31:0] a32;
    v[0] = it.axis_x;
    v[1] = it.axis_y;
    v[2] = it.axis_z;
    o = '0;
    if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
      o.r00 = ONE_Q14;
      o.r11 = ONE_Q14;
      o.r22 = ONE_Q14;
      o.zero_axis = 1'b1;
      return o;
    end
    n2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    q = isqrt64(n2 << 28);
    for (int i = 0; i < 3; i++) u[i] = scale_unit(v[i], q);
    // rotation-mode CORDIC over the residual quarter turn
    a32 = {it.angle_turns, 16'h0};
    z = a32[29:0];
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_step(i);
      end else begin
        x += dx; y -= dy; z += arc_step(i);
      end
    end
    case (a32[31:30])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    omc = (64'sd1 <<< 30) - cs;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = u[i] * u[j] * omc;
    for (int i = 0; i < 3; i++) m[i][i] += cs * (64'sd1 <<< 28);
    m[0][1] -= u[2] * sn * ONE_Q14;
    m[1][0] += u[2] * sn * ONE_Q14;
    m[0][2] += u[1] * sn * ONE_Q14;
    m[2][0] -= u[1] * sn * ONE_Q14;
    m[1][2] -= u[0] * sn * ONE_Q14;
    m[2][1] += u[0] * sn * ONE_Q14;
    o.r00 = round_entry(m[0][0]);
    o.r01 = round_entry(m[0][1]);
    o.r02 = round_entry(m[0][2]);
    o.r10 = round_entry(m[1][0]);
    o.r11 = round_entry(m[1][1]);
    o.r12 = round_entry(m[1][2]);
    o.r20 = round_entry(m[2][0]);
    o.r21 = round_entry(m[2][1]);
    o.r22 = round_entry(m[2][2]);
    return o;
  endfunction

  function automatic in_t axis_item(int ax, int ay, int az, int ang);
    in_t it;
    it.axis_x = ax[15:0];
    it.axis_y = ay[15:0];
    it.axis_z = az[15:0];
    it.angle_turns = ang[15:0];
    return it;
  endfunction

  // Random component: full range, small, zero, or extremes
  function automatic int rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) - 2;
      1: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      2: return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Reset and stimulus
  initial begin
    rst_n = 1'b0;
    pending_axes.push_back(axis_item(0, 0, 0, 0));
    pending_axes.push_back(axis_item(0, 0, 0, 16'h4000));
    pending_axes.push_back(axis_item(32767, 0, 0, 16'h2000));
    pending_axes.push_back(axis_item(0, -32768, 0, 16'h4000));
    pending_axes.push_back(axis_item(0, 0, 32767, 16'h8000));
    pending_axes.push_back(axis_item(-32768, -32768, -32768, 16'hC000));
    pending_axes.push_back(axis_item(32767, 32767, 32767, 16'hFFFF));
    pending_axes.push_back(axis_item(1, 0, 0, 1));
    pending_axes.push_back(axis_item(-1, 1, -1, 16'h7FFF));
    pending_axes.push_back(axis_item(8192, 8192, 0, 16'h1555));
    pending_axes.push_back(axis_item(-32768, 32767, 1, 16'h8001));
    pending_axes.push_back(axis_item(0, 1, 0, 16'h3FFF));
    pending_axes.push_back(axis_item(21845, -21846, 5461, 16'hAAAA));
    pending_axes.push_back(axis_item(0, 0, -1, 16'h5555));
    for (int k = 0; k < RANDOM_ITEMS; k++)
      pending_axes.push_back(axis_item(rand_comp(), rand_comp(), rand_comp(),
                                       $urandom_range(0, 65535)));
    calm_from = pending_axes.size() - CALM_ITEMS;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Drive transactions from the queue with random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      in_data   <= '0;
      gap_left  <= 0;
      n_sent    <= 0;
      stim_done <= 1'b0;
    end else begin
      automatic bit taken = start && !busy;
      automatic int sent = n_sent + (taken ? 1 : 0);
      n_sent <= sent;
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (pending_axes.size() == 0) begin
          start     <= 1'b0;
          stim_done <= 1'b1;
        end else if (sent < calm_from && $urandom_range(0, 19) == 0) begin
          gap_left <= $urandom_range(1, 18) - 1;
          start    <= 1'b0;
        end else begin
          automatic in_t it = pending_axes.pop_front();
          matrix_queue.push_back(rotation_of(it));
          in_data <= it;
          start   <= 1'b1;
        end
      end
    end
  end

  // Check each result against the oldest expected matrix
  always @(posedge clk) begin
    if (!rst_n) begin
      n_checked <= 0;
      n_zero    <= 0;
    end else if (out_valid) begin
      if (matrix_queue.size() == 0) begin
        $error("unexpected result transaction");
        n_errors++;
      end else begin
        automatic out_t e = matrix_queue.pop_front();
        automatic out_t a = out_data;
        if (a.r00 !== e.r00) begin $error("r00 exp %0d got %0d", e.r00, a.r00); n_errors++; end
        if (a.r01 !== e.r01) begin $error("r01 exp %0d got %0d", e.r01, a.r01); n_errors++; end
        if (a.r02 !== e.r02) begin $error("r02 exp %0d got %0d", e.r02, a.r02); n_errors++; end
        if (a.r10 !== e.r10) begin $error("r10 exp %0d got %0d", e.r10, a.r10); n_errors++; end
        if (a.r11 !== e.r11) begin $error("r11 exp %0d got %0d", e.r11, a.r11); n_errors++; end
        if (a.r12 !== e.r12) begin $error("r12 exp %0d got %0d", e.r12, a.r12); n_errors++; end
        if (a.r20 !== e.r20) begin $error("r20 exp %0d got %0d", e.r20, a.r20); n_errors++; end
        if (a.r21 !== e.r21) begin $error("r21 exp %0d got %0d", e.r21, a.r21); n_errors++; end
        if (a.r22 !== e.r22) begin $error("r22 exp %0d got %0d", e.r22, a.r22); n_errors++; end
        if (a.zero_axis !== e.zero_axis) begin
          $error("zero_axis exp %0b got %0b", e.zero_axis, a.zero_axis);
          n_errors++;
        end
        n_checked <= n_checked + 1;
        if (e.zero_axis) n_zero <= n_zero + 1;
      end
    end
  end

  // Watchdog on cycles with no transaction, and end of run
  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", matrix_queue.size());
        $display("RESULT: ERROR");
        $finish;
      end
      if (stim_done && matrix_queue.size() == 0) begin
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d axis-angle transactions, checked %0d matrices (%0d zero axis)",
                 n_sent, n_checked, n_zero);
        if (n_errors == 0 && matrix_queue.size() == 0) begin
          $display("RESULT: OK");
        end else begin
          $display("RESULT: ERROR");
        end
        $finish;
      end
    end
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/aar_pkg.sv
hw/rtl/aar_norm.sv
hw/rtl/aar_cordic.sv
hw/rtl/axis_angle_rotation_matrix.sv
hw/rtl/aar_checker.sv
tb/sv/testbench.sv
